FILE: sv/lrsgd_pkg.sv
// Shared codes, widths and saturation helpers for the linear regression SGD trainer.
package lrsgd_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_RESTART = 3'd0;
  localparam req_t REQ_TRAIN   = 3'd1;
  localparam req_t REQ_PREDICT = 3'd2;
  localparam req_t REQ_EVAL    = 3'd3;
  localparam req_t REQ_REPORT  = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_START = 1'b1;

  localparam int STEP_FRAC = 16;
  localparam int SUM_W     = 48;
  localparam int CNT24_W   = 24;

  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;
  localparam logic [30:0]        CAP31 = 31'h7FFF_FFFF;

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > MAX32) r = MAX32;
    if (v < MIN32) r = MIN32;
    return r[31:0];
  endfunction

  function automatic logic ovf48(input logic signed [63:0] v);
    return (v > MAX48) || (v < MIN48);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > MAX48) r = MAX48;
    if (v < MIN48) r = MIN48;
    return r[47:0];
  endfunction

endpackage

FILE: sv/lrsgd_div.sv
// Restoring divider, one quotient bit per cycle, for the mean loss report.
module lrsgd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lrsgd_pkg::SUM_W-1:0]   dividend_i,
  input  logic [lrsgd_pkg::CNT24_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [lrsgd_pkg::SUM_W-1:0]   quot_o
);
  import lrsgd_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT24_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT24_W-1:0] dvs_q, dvs_d;
  logic [CNT24_W:0]  trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? CNT24_W'(trial - {1'b0, dvs_q}) : trial[CNT24_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("divider done without work");

endmodule

FILE: sv/linear_regression_sgd_trainer.sv
// Top level of the linear regression SGD trainer: sequencer, weight and feature memories.
//
//  Channel   Dir  Payload
//  s_axis    in   tdata: feature, label; tuser: req_type; tlast: last_feature
//  m_axis    out  tdata: prediction, squared_error, mean_loss, samples_counted,
//                 saturated; tuser: result_kind
//  cfg       in   cfg_addr_i 0 step_size, 1 start_weight
//
// A feature item passes through memory read, multiply and accumulate. Closing a sample
// goes through prediction, squaring, loss accumulation and output (prediction and output
// only, in predict mode); in train mode a read-multiply-multiply-write walk over the
// weights and a bias update follow. A report runs the divider only if samples were counted.
// No clearing pass follows reset; weights read as the restart value until written.
// Input is held off while a result waits for a full output register.
module linear_regression_sgd_trainer #(
  parameter int MAX_FEATURES = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // feature[31:0], label[63:32]
  input  logic [2:0]   s_axis_tuser,  // req_type[2:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,  // prediction[31:0], squared_error[62:32],
                                      // mean_loss[93:63], samples_counted[117:94],
                                      // saturated[118], zero[119]
  output logic         m_axis_tuser   // result_kind
);
  import lrsgd_pkg::*;

  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FMUL  = 4'd1;
  localparam logic [3:0] ST_FACC  = 4'd2;
  localparam logic [3:0] ST_PRED  = 4'd3;
  localparam logic [3:0] ST_SQMUL = 4'd4;
  localparam logic [3:0] ST_SQACC = 4'd5;
  localparam logic [3:0] ST_URD   = 4'd6;
  localparam logic [3:0] ST_UMUL1 = 4'd7;
  localparam logic [3:0] ST_UMUL2 = 4'd8;
  localparam logic [3:0] ST_UWR   = 4'd9;
  localparam logic [3:0] ST_BMUL  = 4'd10;
  localparam logic [3:0] ST_BWR   = 4'd11;
  localparam logic [3:0] ST_DIV   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0] state_q;
  logic [16:0] step_q;
  logic signed [31:0] start_q, rst_val_q;
  req_t req_q;
  logic signed [31:0] x_q, label_q, bias_q, pred_q, g_q, wr_q;
  logic last_q;
  logic signed [47:0] dot_q;
  logic signed [32:0] err_q;
  logic signed [63:0] prod_q;
  logic [30:0] sq_q;
  logic big_q;
  logic [CNT_W-1:0] fcnt_q, j_q;
  logic ssat_q, sumsat_q;
  logic [SUM_W-1:0] loss_q, quot_q;
  logic [CNT24_W-1:0] scnt_q;
  logic [MAX_FEATURES-1:0] wv_q;

  logic signed [31:0] wmem [MAX_FEATURES];
  logic signed [31:0] fmem [MAX_FEATURES];
  logic signed [31:0] w_rdata_q, f_rdata_q;
  logic wv_rd_q;

  logic out_valid_q, out_kind_q, out_sat_q;
  logic signed [31:0] out_pred_q;
  logic [30:0] out_sq_q, out_mean_q;
  logic [CNT24_W-1:0] out_cnt_q;

  logic in_fire, out_free, div_start, div_done;
  logic [SUM_W-1:0] div_quot;
  logic [IDX_W-1:0] fidx, jidx, w_raddr;
  logic fwe, wwe;
  logic signed [31:0] w_eff, grad_c, nw_c, nb_c, pred_c;
  logic signed [63:0] acc_c, psum_c, err64, neg2_c, g64, nw64, nb64;
  logic [63:0] mag64;
  logic [63:0] sqsh_c;
  logic [30:0] sq_c;
  logic [SUM_W:0] loss_c;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign fidx = fcnt_q[IDX_W-1:0];
  assign jidx = j_q[IDX_W-1:0];
  assign w_raddr = (state_q == ST_IDLE) ? fidx : jidx;
  assign fwe = in_fire && (s_axis_tuser == REQ_TRAIN || s_axis_tuser == REQ_PREDICT ||
               s_axis_tuser == REQ_EVAL) && (fcnt_q < CNT_W'(MAX_FEATURES));
  assign wwe = (state_q == ST_UWR);

  assign w_eff  = wv_rd_q ? w_rdata_q : rst_val_q;
  assign acc_c  = dot_q + (prod_q >>> FRAC_BITS);
  assign psum_c = dot_q + bias_q;
  assign pred_c = sat32(psum_c);
  assign err64  = err_q;
  assign neg2_c = -(err64 * 64'sd2);
  assign mag64  = (err64 < 0) ? 64'(-err64) : 64'(err64);
  assign sqsh_c = 64'(prod_q) >> FRAC_BITS;
  assign sq_c   = (big_q || sqsh_c > 64'(CAP31)) ? CAP31 : sqsh_c[30:0];
  assign loss_c = {1'b0, loss_q} + (SUM_W + 1)'(sq_c);
  assign g64    = prod_q >>> FRAC_BITS;
  assign grad_c = sat32(g64);
  assign nw64   = wr_q - (prod_q >>> STEP_FRAC);
  assign nw_c   = sat32(nw64);
  assign nb64   = bias_q - (prod_q >>> STEP_FRAC);
  assign nb_c   = sat32(nb64);
  assign div_start = in_fire && s_axis_tuser == REQ_REPORT && scnt_q != '0;

  lrsgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (loss_q),
    .divisor_i  (scnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[fidx] <= $signed(s_axis_tdata[31:0]);
    end
    if (wwe) begin
      wmem[jidx] <= nw_c;
    end
    w_rdata_q <= wmem[w_raddr];
    f_rdata_q <= fmem[jidx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 17'd655;
      start_q     <= 32'sd66;
      rst_val_q   <= 32'sd66;
      wv_q        <= '0;
      wv_rd_q     <= 1'b0;
      bias_q      <= '0;
      dot_q       <= '0;
      fcnt_q      <= '0;
      j_q         <= '0;
      ssat_q      <= 1'b0;
      sumsat_q    <= 1'b0;
      loss_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_STEP:  step_q  <= cfg_data_i[16:0];
          REG_START: start_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_q && m_axis_tready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      wv_rd_q <= wv_q[w_raddr];
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            req_q   <= s_axis_tuser;
            x_q     <= $signed(s_axis_tdata[31:0]);
            label_q <= $signed(s_axis_tdata[63:32]);
            last_q  <= s_axis_tlast;
            case (s_axis_tuser)
              REQ_RESTART: begin
                rst_val_q <= start_q;
                wv_q      <= '0;
                bias_q    <= '0;
                loss_q    <= '0;
                scnt_q    <= '0;
                sumsat_q  <= 1'b0;
                fcnt_q    <= '0;
                dot_q     <= '0;
                ssat_q    <= 1'b0;
              end
              REQ_REPORT: begin
                quot_q  <= '0;
                state_q <= (scnt_q != '0) ? ST_DIV : ST_OUT;
              end
              REQ_TRAIN, REQ_PREDICT, REQ_EVAL: begin
                if (fcnt_q < CNT_W'(MAX_FEATURES)) begin
                  state_q <= ST_FMUL;
                end else begin
                  ssat_q <= 1'b1;
                  if (s_axis_tlast) begin
                    state_q <= ST_PRED;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_FMUL: begin
          prod_q  <= w_eff * x_q;
          state_q <= ST_FACC;
        end
        ST_FACC: begin
          dot_q  <= sat48(acc_c);
          if (ovf48(acc_c)) ssat_q <= 1'b1;
          fcnt_q  <= fcnt_q + CNT_W'(1);
          state_q <= last_q ? ST_PRED : ST_IDLE;
        end
        ST_PRED: begin
          pred_q <= pred_c;
          err_q  <= 33'(label_q - pred_c);
          if (ovf32(psum_c)) ssat_q <= 1'b1;
          sq_q    <= '0;
          state_q <= (req_q == REQ_PREDICT) ? ST_OUT : ST_SQMUL;
        end
        ST_SQMUL: begin
          big_q   <= mag64[32];
          prod_q  <= $signed({32'b0, mag64[31:0]} * {32'b0, mag64[31:0]});
          g_q     <= sat32(neg2_c);
          if (req_q == REQ_TRAIN && ovf32(neg2_c)) ssat_q <= 1'b1;
          state_q <= ST_SQACC;
        end
        ST_SQACC: begin
          sq_q <= sq_c;
          if (big_q || sqsh_c > 64'(CAP31)) ssat_q <= 1'b1;
          if (loss_c[SUM_W]) begin
            loss_q <= '1;
          end else begin
            loss_q <= loss_c[SUM_W-1:0];
          end
          if (loss_c[SUM_W] || scnt_q == '1) begin
            sumsat_q <= 1'b1;
          end
          if (scnt_q != '1) begin
            scnt_q <= scnt_q + CNT24_W'(1);
          end
          j_q <= '0;
          if (req_q == REQ_TRAIN) begin
            state_q <= (fcnt_q != '0) ? ST_URD : ST_BMUL;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_URD: begin
          state_q <= ST_UMUL1;
        end
        ST_UMUL1: begin
          prod_q  <= g_q * f_rdata_q;
          wr_q    <= w_eff;
          state_q <= ST_UMUL2;
        end
        ST_UMUL2: begin
          if (ovf32(g64)) ssat_q <= 1'b1;
          prod_q  <= $signed({1'b0, step_q}) * grad_c;
          state_q <= ST_UWR;
        end
        ST_UWR: begin
          if (ovf32(nw64)) ssat_q <= 1'b1;
          wv_q[jidx] <= 1'b1;
          j_q <= j_q + CNT_W'(1);
          state_q <= (j_q + CNT_W'(1) == fcnt_q) ? ST_BMUL : ST_URD;
        end
        ST_BMUL: begin
          prod_q  <= $signed({1'b0, step_q}) * g_q;
          state_q <= ST_BWR;
        end
        ST_BWR: begin
          if (ovf32(nb64)) ssat_q <= 1'b1;
          bias_q  <= nb_c;
          state_q <= ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            quot_q  <= div_quot;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cnt_q   <= scnt_q;
            if (req_q == REQ_REPORT) begin
              out_kind_q <= KIND_REPORT;
              out_pred_q <= '0;
              out_sq_q   <= '0;
              out_mean_q <= (quot_q > SUM_W'(CAP31)) ? CAP31 : quot_q[30:0];
              out_sat_q  <= sumsat_q || (quot_q > SUM_W'(CAP31));
              loss_q     <= '0;
              scnt_q     <= '0;
              sumsat_q   <= 1'b0;
            end else begin
              out_kind_q <= KIND_SAMPLE;
              out_pred_q <= pred_q;
              out_sq_q   <= sq_q;
              out_mean_q <= '0;
              out_sat_q  <= ssat_q;
              if (ssat_q && req_q != REQ_PREDICT) sumsat_q <= 1'b1;
              fcnt_q <= '0;
              dot_q  <= '0;
              ssat_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {1'b0, out_sat_q, out_cnt_q, out_mean_q, out_sq_q, out_pred_q};

  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CNT_W'(MAX_FEATURES)) else $error("feature count beyond capacity");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == REQ_RESTART |=> loss_q == '0 && scnt_q == '0 &&
    fcnt_q == '0 && wv_q == '0) else $error("restart left state behind");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("divider finished outside report");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UWR |-> j_q < fcnt_q) else $error("weight walk past feature count");

endmodule

FILE: tb/lrsgd_checker.sv
// Beat monitor, cycle-free predictor and result scoreboard for the SGD trainer.
module lrsgd_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // feature[31:0], label[63:32]
  input  logic [2:0]   s_axis_tuser,  // req_type[2:0]
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,  // prediction, squared_error, mean_loss,
                                      // samples_counted, saturated, zero
  input  logic         m_axis_tuser,  // result_kind
  output int           pending_o,
  output int           errors_o,
  output logic         beat_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrsgd_pkg::*;

  localparam int NF = 16;
  localparam longint CAP48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint CAP24 = 64'h0000_0000_00FF_FFFF;

  typedef struct {
    logic        kind;
    logic [31:0] pred;
    logic [30:0] sq;
    logic [30:0] mean;
    logic [23:0] cnt;
    logic        sat;
  } outcome_t;

  outcome_t expected_q[$];
  int       mismatches;
  int       outstanding;

  longint      weight[NF];
  longint      bias, dot_acc, loss_sum, sample_cnt, step, start_w;
  longint      fbuf[NF];
  int unsigned fcnt;
  bit          sample_sat, sum_sat;

  assign pending_o = outstanding;
  assign errors_o  = mismatches;
  assign beat_o    = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                     cfg_we_i;

  function automatic longint clip(longint v, longint lo, longint hi, inout bit f);
    if (v > hi) begin
      f = 1'b1;
      return hi;
    end
    if (v < lo) begin
      f = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void clear_sample();
    fcnt = 0;
    dot_acc = 0;
    sample_sat = 1'b0;
  endfunction

  function automatic void restart_model();
    for (int i = 0; i < NF; i++) weight[i] = start_w;
    bias = 0;
    loss_sum = 0;
    sample_cnt = 0;
    sum_sat = 1'b0;
    clear_sample();
  endfunction

  function automatic void predict_beat(logic [2:0] req, logic [63:0] data, logic last);
    longint    x, label, pred, err, g, grad, term, mag, sqv, mean;
    logic [63:0] msq;
    outcome_t  o;
    x = longint'($signed(data[31:0]));
    label = longint'($signed(data[63:32]));
    if (req == REQ_RESTART) begin
      restart_model();
      return;
    end
    if (req == REQ_REPORT) begin
      mean = 0;
      if (sample_cnt != 0) mean = loss_sum / sample_cnt;
      if (mean > MAX32) begin
        mean = MAX32;
        sum_sat = 1'b1;
      end
      o.kind = KIND_REPORT;
      o.pred = '0;
      o.sq = '0;
      o.mean = mean[30:0];
      o.cnt = sample_cnt[23:0];
      o.sat = sum_sat;
      expected_q.insert(expected_q.size(), o);
      loss_sum = 0;
      sample_cnt = 0;
      sum_sat = 1'b0;
      return;
    end
    if (req > REQ_REPORT) return;
    if (fcnt < NF) begin
      fbuf[fcnt] = x;
      dot_acc = clip(dot_acc + ((weight[fcnt] * x) >>> 16), MIN48, MAX48, sample_sat);
      fcnt++;
    end else begin
      sample_sat = 1'b1;
    end
    if (!last) return;
    pred = clip(dot_acc + bias, MIN32, MAX32, sample_sat);
    err = label - pred;
    sqv = 0;
    if (req != REQ_PREDICT) begin
      mag = (err < 0) ? -err : err;
      if (mag >= 64'h1_0000_0000) begin
        sqv = MAX32;
        sample_sat = 1'b1;
      end else begin
        msq = 64'(mag) * 64'(mag);
        sqv = longint'(msq >> 16);
        if (sqv > MAX32) begin
          sqv = MAX32;
          sample_sat = 1'b1;
        end
      end
      loss_sum += sqv;
      if (loss_sum > CAP48) begin
        loss_sum = CAP48;
        sum_sat = 1'b1;
      end
      if (sample_cnt < CAP24) sample_cnt++;
      else sum_sat = 1'b1;
    end
    if (req == REQ_TRAIN) begin
      g = clip(-2 * err, MIN32, MAX32, sample_sat);
      for (int j = 0; j < fcnt; j++) begin
        grad = clip((g * fbuf[j]) >>> 16, MIN32, MAX32, sample_sat);
        term = (step * grad) >>> STEP_FRAC;
        weight[j] = clip(weight[j] - term, MIN32, MAX32, sample_sat);
      end
      term = (step * g) >>> STEP_FRAC;
      bias = clip(bias - term, MIN32, MAX32, sample_sat);
    end
    if (sample_sat) sum_sat = sum_sat || (req != REQ_PREDICT);
    o.kind = KIND_SAMPLE;
    o.pred = pred[31:0];
    o.sq = sqv[30:0];
    o.mean = '0;
    o.cnt = sample_cnt[23:0];
    o.sat = sample_sat;
    expected_q.insert(expected_q.size(), o);
    clear_sample();
  endfunction

  function automatic void check_result(logic kind, logic [119:0] d);
    outcome_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat: kind %0d data %h", kind, d);
      return;
    end
    e = expected_q.pop_front();
    if (kind !== e.kind || d[31:0] !== e.pred || d[62:32] !== e.sq || d[93:63] !== e.mean ||
        d[117:94] !== e.cnt || d[118] !== e.sat) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Result mismatch: expected kind %0d pred %h sq %h mean %h cnt %0d sat %0d",
                 e.kind, e.pred, e.sq, e.mean, e.cnt, e.sat);
        $display("                 got      kind %0d pred %h sq %h mean %h cnt %0d sat %0d",
                 kind, d[31:0], d[62:32], d[93:63], d[117:94], d[118]);
      end
    end
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step = 655;
      start_w = 66;
      restart_model();
      expected_q.delete();
      outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tuser, m_axis_tdata);
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_STEP) step = longint'(cfg_data_i[16:0]);
        else start_w = longint'($signed(cfg_data_i));
      end
      if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      outstanding = expected_q.size();
    end
  end

endmodule

FILE: tb/linear_regression_sgd_trainer_tb.sv
// Stimulus, clocking and verdict for the linear regression SGD trainer testbench.
module linear_regression_sgd_trainer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrsgd_pkg::*;

  localparam int WATCHDOG = 4000;
  localparam int SETTLE   = 120;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_addr_i = 1'b0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           pending, errors, quiet_cycles;
  logic         beat;
  bit           idle_on = 1'b1;
  int           items_sent = 0;

  always #5 clk_i = ~clk_i;

  linear_regression_sgd_trainer DUT (.*);

  lrsgd_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .errors_o(errors), .beat_o(beat)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || beat) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(19);
    if (r < 14) return 32'($urandom_range(32'h60000) - 32'h30000);
    if (r < 17) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0001_0000;
      default: return 32'h0;
    endcase
  endfunction

  task automatic send_beat(logic [2:0] req, logic [31:0] feat, logic [31:0] label, logic last);
    while (idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {label, feat};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [2:0] mode, int nfeat);
    logic [2:0] req;
    for (int i = 0; i < nfeat; i++) begin
      req = ($urandom_range(9) == 0) ? 3'($urandom_range(REQ_EVAL, REQ_TRAIN)) : mode;
      if (i == nfeat - 1) req = mode;
      send_beat(req, pick_value(), pick_value(), i == nfeat - 1);
    end
  endtask

  task automatic random_phase(int n);
    int target, r, nfeat;
    logic [2:0] mode;
    target = items_sent + n;
    while (items_sent < target) begin
      idle_on = !(items_sent > 300 && items_sent < 420);
      r = $urandom_range(99);
      if (r < 8) begin
        send_beat(REQ_REPORT, $urandom, $urandom, 1'($urandom));
      end else if (r < 10) begin
        send_beat(REQ_RESTART, $urandom, $urandom, 1'($urandom));
      end else if (r < 12) begin
        send_beat(3'($urandom_range(7, 5)), $urandom, $urandom, 1'($urandom));
      end else begin
        r = $urandom_range(9);
        mode = (r < 5) ? REQ_TRAIN : (r < 8) ? REQ_EVAL : REQ_PREDICT;
        nfeat = ($urandom_range(14) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 1);
        if ($urandom_range(5) == 0) nfeat = $urandom_range(16, 7);
        send_sample(mode, nfeat);
      end
    end
    idle_on = 1'b1;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(REQ_REPORT, '0, '0, 1'b0);
    send_beat(REQ_TRAIN, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_beat(REQ_PREDICT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_beat(REQ_EVAL, 32'h0, 32'h7FFF_FFFF, 1'b1);
    send_beat(REQ_EVAL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    for (int i = 0; i < 17; i++) send_beat(REQ_TRAIN, 32'h0001_0000, 32'h0002_0000, i == 16);
    send_beat(REQ_PREDICT, 32'h0002_0000, '0, 1'b0);
    send_beat(REQ_TRAIN, 32'hFFFF_0000, 32'h0001_8000, 1'b1);
    send_beat(3'd5, 32'h1234_5678, '0, 1'b1);
    send_beat(3'd7, '0, '0, 1'b0);
    send_beat(REQ_TRAIN, 32'h0003_0000, '0, 1'b0);
    send_beat(REQ_RESTART, '0, '0, 1'b1);
    send_beat(REQ_REPORT, '0, '0, 1'b1);
    drain();

    random_phase(170);
    write_reg(REG_STEP, 32'd0);
    write_reg(REG_START, 32'h8000_0000);
    send_beat(REQ_RESTART, '0, '0, 1'b0);
    random_phase(170);
    write_reg(REG_STEP, 32'd65536);
    write_reg(REG_START, 32'h7FFF_FFFF);
    send_beat(REQ_RESTART, '0, '0, 1'b0);
    random_phase(170);
    write_reg(REG_STEP, 32'd100000);
    write_reg(REG_START, 32'h0001_0000);
    send_beat(REQ_RESTART, '0, '0, 1'b0);
    random_phase(170);
    write_reg(REG_STEP, 32'($urandom_range(65536)));
    write_reg(REG_START, 32'($urandom_range(32'h20000)) - 32'h10000);
    send_beat(REQ_RESTART, '0, '0, 1'b0);
    random_phase(170);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: linear_regression_sgd_trainer.f
sv/lrsgd_pkg.sv
sv/lrsgd_div.sv
sv/linear_regression_sgd_trainer.sv
tb/lrsgd_checker.sv
tb/linear_regression_sgd_trainer_tb.sv
